@@ rtl/core/sedc_pkg.sv @@
// ----------------------------------------------------------------------------
// Sediment cell package
// Shared types, register indexes and constants of the erosion/deposition cell.
// ----------------------------------------------------------------------------
package sedc_pkg;

  typedef enum logic [1:0] {
    CFG_RHO_G        = 2'd0,
    CFG_MIN_DEPTH    = 2'd1,
    CFG_SETTLE_SPEED = 2'd2,
    CFG_TIME_STEP    = 2'd3
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [15:0] RHO_G_RST        = 16'd9810;
  localparam logic [15:0] MIN_DEPTH_RST    = 16'd26;
  localparam logic [31:0] SETTLE_SPEED_RST = 32'd4294967;
  localparam logic [23:0] TIME_STEP_RST    = 24'd76800;

  // Chezy 10.0 and 50.0 in Q8.8
  localparam logic [15:0] CHEZY_LOW = 16'd2560;
  localparam logic [15:0] CHEZY_SUB = 16'd12800;
  // g/L to kg scaling of the deposition flux
  localparam logic [33:0] MILLI_DIV = 34'd1000;

  localparam logic [47:0] RATE_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] CONC_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [15:0] flow_speed;
    logic [15:0]        water_depth;
    logic [15:0]        friction_coef;
    logic [23:0]        erosion_threshold;
    logic [23:0]        deposit_threshold;
    logic [31:0]        erosion_coef;
    logic [31:0]        concentration;
  } cell_in_t;

  typedef struct packed {
    logic [47:0] erosion_area_rate;
    logic [47:0] erosion_volume_rate;
    logic [47:0] deposit_area_rate;
    logic [47:0] deposit_volume_rate;
    logic [31:0] new_concentration;
  } cell_out_t;

endpackage

@@ rtl/core/sedc_stream_if.sv @@
// ----------------------------------------------------------------------------
// Sediment cell stream interface
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface sedc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/sedc_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Two quotient bits per stage; expects num[top DEN_W bits] < den.
// ----------------------------------------------------------------------------
module sedc_div #(
  parameter int unsigned DEN_W  = 24,
  parameter int unsigned QUO_W  = 48,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [DEN_W+QUO_W-1:0] num_i,
  input  logic [DEN_W-1:0]       den_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   valid_o,
  output logic [QUO_W-1:0]       quo_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int unsigned NST = QUO_W / 2;

  logic [DEN_W-1:0]  rem_q  [NST];
  logic [QUO_W-1:0]  acc_q  [NST];
  logic [DEN_W-1:0]  den_q  [NST];
  logic [SIDE_W-1:0] side_q [NST];
  logic              vld_q  [NST];

  function automatic logic [DEN_W+QUO_W-1:0] div_step2(
    input logic [DEN_W-1:0] rem,
    input logic [QUO_W-1:0] acc,
    input logic [DEN_W-1:0] den
  );
    logic [DEN_W:0]   t;
    logic [DEN_W-1:0] r;
    logic [QUO_W-1:0] a;
    r = rem;
    a = acc;
    for (int k = 0; k < 2; k++) begin
      t = {r, a[QUO_W-1]};
      a = {a[QUO_W-2:0], 1'b0};
      if (t >= {1'b0, den}) begin
        t    = t - {1'b0, den};
        a[0] = 1'b1;
      end
      r = t[DEN_W-1:0];
    end
    return {r, a};
  endfunction

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [DEN_W-1:0]  rem_in;
    logic [QUO_W-1:0]  acc_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [DEN_W-1:0]  rem_d;
    logic [QUO_W-1:0]  acc_d;

    if (s == 0) begin : g_first
      assign rem_in  = num_i[DEN_W+QUO_W-1:QUO_W];
      assign acc_in  = num_i[QUO_W-1:0];
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign acc_in  = acc_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    assign {rem_d, acc_d} = div_step2(rem_in, acc_in, den_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        acc_q[s]  <= acc_d;
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign quo_o   = acc_q[NST-1];
  assign side_o  = side_q[NST-1];

endmodule

@@ rtl/core/sediment_erosion_deposition_cell.sv @@
// ----------------------------------------------------------------------------
// Sediment erosion/deposition cell
// Bed shear stress, erosion and deposition rates and concentration update.
// ----------------------------------------------------------------------------
// Throughput: one cell per cycle; the tau divider (16 stages) and the rate and
// volume dividers (24 stages each) are fully pipelined, two quotient bits a stage.
// The whole pipeline holds while a result waits in the output register.
// Reset clears all valid bits and loads the default register values.
module sediment_erosion_deposition_cell
  import sedc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sedc_stream_if.sink           in_i,
  sedc_stream_if.source         out_o
);

  logic [15:0] rho_g_q, min_depth_q;
  logic [31:0] settle_q;
  logic [23:0] ts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rho_g_q     <= RHO_G_RST;
      min_depth_q <= MIN_DEPTH_RST;
      settle_q    <= SETTLE_SPEED_RST;
      ts_q        <= TIME_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RHO_G:        rho_g_q     <= cfg_data_i[15:0];
        CFG_MIN_DEPTH:    min_depth_q <= cfg_data_i[15:0];
        CFG_SETTLE_SPEED: settle_q    <= cfg_data_i[31:0];
        CFG_TIME_STEP:    ts_q        <= cfg_data_i[23:0];
      endcase
    end
  end

  logic en;
  logic out_vld_q;
  cell_out_t out_q;

  assign en          = !out_vld_q || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // ---- stage 1: speed magnitude, squares
  logic [15:0] u_abs, chz;
  logic        s1_vld_q;
  logic [30:0] usq_q;
  logic [31:0] c2_q;
  logic [127:0] s1_side_q;

  assign u_abs = in_i.data.flow_speed[15] ? (~in_i.data.flow_speed + 16'd1)
                                          : in_i.data.flow_speed;
  assign chz   = (in_i.data.friction_coef < CHEZY_LOW) ? CHEZY_SUB
                                                       : in_i.data.friction_coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      usq_q     <= 31'(32'(u_abs) * 32'(u_abs));
      c2_q      <= 32'(chz) * 32'(chz);
      s1_side_q <= {in_i.data.water_depth, in_i.data.erosion_threshold,
                    in_i.data.deposit_threshold, in_i.data.erosion_coef,
                    in_i.data.concentration};
    end
  end

  // ---- stage 2: rho_g * U^2
  logic        s2_vld_q;
  logic [46:0] prod_q;
  logic [31:0] s2_c2_q;
  logic [127:0] s2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q    <= 47'(rho_g_q) * 47'(usq_q);
      s2_c2_q   <= c2_q;
      s2_side_q <= s1_side_q;
    end
  end

  // ---- tau = rho_g * U^2 * 256 / C^2 (C^2 >= 2^22 keeps quotient in 32 bits)
  logic         tau_vld;
  logic [31:0]  tau;
  logic [127:0] tau_side;

  sedc_div #(.DEN_W(32), .QUO_W(32), .SIDE_W(128)) u_tau_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_vld_q),
    .num_i   ({9'd0, prod_q, 8'd0}),
    .den_i   (s2_c2_q),
    .side_i  (s2_side_q),
    .valid_o (tau_vld),
    .quo_o   (tau),
    .side_o  (tau_side)
  );

  logic [15:0] t_depth;
  logic [23:0] t_tau_e, t_tau_d;
  logic [31:0] t_mero, t_conc;
  assign {t_depth, t_tau_e, t_tau_d, t_mero, t_conc} = tau_side;

  // ---- stage 3: threshold tests, settle * conc
  logic        s3_vld_q, s3_ge_q, s3_gd_q;
  logic [31:0] s3_diff_q, s3_mero_q, s3_conc_q;
  logic [23:0] s3_k_q, s3_tau_e_q, s3_tau_d_q;
  logic [15:0] s3_depth_q;
  logic [63:0] s3_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= tau_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_ge_q    <= (t_tau_e != 24'd0) && (tau >= 32'(t_tau_e));
      s3_gd_q    <= (t_tau_d != 24'd0) && (tau <= 32'(t_tau_d));
      s3_diff_q  <= tau - 32'(t_tau_e);
      s3_k_q     <= t_tau_d - tau[23:0];
      s3_p_q     <= 64'(settle_q) * 64'(t_conc);
      s3_mero_q  <= t_mero;
      s3_tau_e_q <= t_tau_e;
      s3_tau_d_q <= t_tau_d;
      s3_depth_q <= t_depth;
      s3_conc_q  <= t_conc;
    end
  end

  // ---- stage 4: partial products
  logic        s4_vld_q, s4_ge_q, s4_gd_q;
  logic [63:0] s4_eprod_q;
  logic [55:0] s4_dlo_q, s4_dhi_q;
  logic [33:0] s4_den_d_q;
  logic [23:0] s4_tau_e_q;
  logic [15:0] s4_depth_q;
  logic [31:0] s4_conc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_eprod_q <= 64'(s3_diff_q) * 64'(s3_mero_q);
      s4_dlo_q   <= 56'(s3_p_q[31:0]) * 56'(s3_k_q);
      s4_dhi_q   <= 56'(s3_p_q[63:32]) * 56'(s3_k_q);
      s4_den_d_q <= 34'(s3_tau_d_q) * MILLI_DIV;
      s4_ge_q    <= s3_ge_q;
      s4_gd_q    <= s3_gd_q;
      s4_tau_e_q <= s3_tau_e_q;
      s4_depth_q <= s3_depth_q;
      s4_conc_q  <= s3_conc_q;
    end
  end

  // ---- stage 5: deposition dividend, saturation tests
  logic [87:0] dd;
  logic        s5_vld_q, s5_ezero_q, s5_esat_q, s5_dzero_q, s5_dsat_q;
  logic [63:0] s5_eprod_q;
  logic [81:0] s5_dd_q;
  logic [33:0] s5_den_d_q;
  logic [23:0] s5_tau_e_q;
  logic [15:0] s5_depth_q;
  logic [31:0] s5_conc_q;

  assign dd = {s4_dhi_q, 32'd0} + 88'(s4_dlo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_ezero_q <= !s4_ge_q;
      s5_esat_q  <= 24'(s4_eprod_q[63:48]) >= s4_tau_e_q;
      s5_dzero_q <= !s4_gd_q;
      s5_dsat_q  <= dd[87:48] >= 40'(s4_den_d_q);
      s5_eprod_q <= s4_eprod_q;
      s5_dd_q    <= dd[81:0];
      s5_den_d_q <= s4_den_d_q;
      s5_tau_e_q <= s4_tau_e_q;
      s5_depth_q <= s4_depth_q;
      s5_conc_q  <= s4_conc_q;
    end
  end

  // ---- area rate dividers
  logic        ero_vld, dep_vld;
  logic [47:0] ero_quo, dep_quo;
  logic [49:0] ero_side;
  logic [1:0]  dep_side;

  sedc_div #(.DEN_W(24), .QUO_W(48), .SIDE_W(50)) u_ero_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_vld_q),
    .num_i   ({8'd0, s5_eprod_q}),
    .den_i   (s5_tau_e_q),
    .side_i  ({s5_ezero_q, s5_esat_q, s5_depth_q, s5_conc_q}),
    .valid_o (ero_vld),
    .quo_o   (ero_quo),
    .side_o  (ero_side)
  );

  sedc_div #(.DEN_W(34), .QUO_W(48), .SIDE_W(2)) u_dep_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_vld_q),
    .num_i   (s5_dd_q),
    .den_i   (s5_den_d_q),
    .side_i  ({s5_dzero_q, s5_dsat_q}),
    .valid_o (dep_vld),
    .quo_o   (dep_quo),
    .side_o  (dep_side)
  );

  logic        a_ezero, a_esat;
  logic [15:0] a_depth, dfl;
  logic [31:0] a_conc;
  logic [47:0] ea, da;
  assign {a_ezero, a_esat, a_depth, a_conc} = ero_side;

  always_comb begin
    priority if (a_ezero) ea = '0;
    else if (a_esat)      ea = RATE_MAX;
    else                  ea = ero_quo;
    priority if (dep_side[1]) da = '0;
    else if (dep_side[0])     da = RATE_MAX;
    else                      da = dep_quo;
  end

  assign dfl = (a_depth < min_depth_q) ? min_depth_q : a_depth;

  // ---- stage 7: area rates, floored depth
  logic        s7_vld_q, s7_evsat_q, s7_dvsat_q;
  logic [47:0] s7_ea_q, s7_da_q;
  logic [15:0] s7_d_q;
  logic [31:0] s7_conc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else if (en) begin
      s7_vld_q <= ero_vld;
    end
  end

  // zero depth floor: saturate only a nonzero rate
  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_evsat_q <= (ea != '0) && (16'(ea[47:40]) >= dfl);
      s7_dvsat_q <= (da != '0) && (16'(da[47:40]) >= dfl);
      s7_ea_q    <= ea;
      s7_da_q    <= da;
      s7_d_q     <= dfl;
      s7_conc_q  <= a_conc;
    end
  end

  // ---- volume rate dividers
  logic         ev_vld, dv_vld;
  logic [47:0]  ev_quo, dv_quo;
  logic [128:0] ev_side;
  logic         dv_side;

  sedc_div #(.DEN_W(16), .QUO_W(48), .SIDE_W(129)) u_ev_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s7_vld_q),
    .num_i   ({8'd0, s7_ea_q, 8'd0}),
    .den_i   (s7_d_q),
    .side_i  ({s7_evsat_q, s7_ea_q, s7_da_q, s7_conc_q}),
    .valid_o (ev_vld),
    .quo_o   (ev_quo),
    .side_o  (ev_side)
  );

  sedc_div #(.DEN_W(16), .QUO_W(48), .SIDE_W(1)) u_dv_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s7_vld_q),
    .num_i   ({8'd0, s7_da_q, 8'd0}),
    .den_i   (s7_d_q),
    .side_i  (s7_dvsat_q),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  logic        v_evsat;
  logic [47:0] v_ea, v_da, ev, dv;
  logic [31:0] v_conc;
  assign {v_evsat, v_ea, v_da, v_conc} = ev_side;
  // a zero depth floor makes the divider return all ones for a zero rate
  assign ev = v_evsat ? RATE_MAX : (v_ea == '0) ? '0 : ev_quo;
  assign dv = dv_side ? RATE_MAX : (v_da == '0) ? '0 : dv_quo;

  // ---- stage 8: net volume rate
  logic        s8_vld_q, s8_neg_q;
  logic [47:0] s8_ea_q, s8_da_q, s8_ev_q, s8_dv_q, s8_m_q;
  logic [31:0] s8_conc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q <= 1'b0;
    end else if (en) begin
      s8_vld_q <= ev_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_neg_q  <= dv > ev;
      s8_m_q    <= (dv > ev) ? (dv - ev) : (ev - dv);
      s8_ea_q   <= v_ea;
      s8_da_q   <= v_da;
      s8_ev_q   <= ev;
      s8_dv_q   <= dv;
      s8_conc_q <= v_conc;
    end
  end

  // ---- stage 9: |Ev - Dv| * dt partials
  logic        s9_vld_q, s9_neg_q;
  logic [55:0] s9_plo_q;
  logic [39:0] s9_phi_q;
  logic [47:0] s9_ea_q, s9_da_q, s9_ev_q, s9_dv_q;
  logic [31:0] s9_conc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_vld_q <= 1'b0;
    end else if (en) begin
      s9_vld_q <= s8_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_plo_q  <= 56'(s8_m_q[31:0]) * 56'(ts_q);
      s9_phi_q  <= 40'(s8_m_q[47:32]) * 40'(ts_q);
      s9_neg_q  <= s8_neg_q;
      s9_ea_q   <= s8_ea_q;
      s9_da_q   <= s8_da_q;
      s9_ev_q   <= s8_ev_q;
      s9_dv_q   <= s8_dv_q;
      s9_conc_q <= s8_conc_q;
    end
  end

  // ---- stage 10: delta = product >> 40
  logic [71:0] psum;
  logic        s10_vld_q, s10_neg_q;
  logic [31:0] s10_delta_q, s10_conc_q;
  logic [47:0] s10_ea_q, s10_da_q, s10_ev_q, s10_dv_q;

  assign psum = {s9_phi_q, 32'd0} + 72'(s9_plo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s10_vld_q <= 1'b0;
    end else if (en) begin
      s10_vld_q <= s9_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s10_delta_q <= psum[71:40];
      s10_neg_q   <= s9_neg_q;
      s10_ea_q    <= s9_ea_q;
      s10_da_q    <= s9_da_q;
      s10_ev_q    <= s9_ev_q;
      s10_dv_q    <= s9_dv_q;
      s10_conc_q  <= s9_conc_q;
    end
  end

  // ---- output register: clamp at zero, saturate at top
  logic [32:0] csum;
  logic [31:0] nc;

  assign csum = 33'(s10_conc_q) + 33'(s10_delta_q);

  always_comb begin
    if (s10_neg_q) begin
      nc = (s10_delta_q >= s10_conc_q) ? 32'd0 : (s10_conc_q - s10_delta_q);
    end else begin
      nc = csum[32] ? CONC_MAX : csum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= s10_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.erosion_area_rate   <= s10_ea_q;
      out_q.erosion_volume_rate <= s10_ev_q;
      out_q.deposit_area_rate   <= s10_da_q;
      out_q.deposit_volume_rate <= s10_dv_q;
      out_q.new_concentration   <= nc;
    end
  end

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with empty output register");

  a_rate_divs_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ero_vld == dep_vld) && (ev_vld == dv_vld))
    else $error("parallel dividers out of step");

  a_ero_zero_vol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.data.erosion_area_rate == '0)
      |-> (out_o.data.erosion_volume_rate == '0))
    else $error("erosion volume rate without area rate");

  a_dep_zero_vol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.data.deposit_area_rate == '0)
      |-> (out_o.data.deposit_volume_rate == '0))
    else $error("deposition volume rate without area rate");
`endif

endmodule
